// ----- rtl/wlc_pkg.sv -----
// Package for the weighted least-connection picker: item types, codes and control structs.
package wlc_pkg;

    // Function codes of an input word.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_SCHED = 1'b1;

    // One input word.
    typedef struct packed {
        logic        func;
        logic [5:0]  entry_index;
        logic [15:0] entry_weight;
        logic        entry_overloaded;
        logic [31:0] entry_overhead;
    } t_item;

    // One result word.
    typedef struct packed {
        logic        found;
        logic [5:0]  chosen_index;
        logic [31:0] chosen_overhead;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;     // write zeros to the entry under the sweep counter
        logic wr;      // write the input word into its table entry
        logic init;    // start a scan: clear the best entry, read entry zero
        logic mul;     // form both cross products, read the following entry
        logic cmp;     // compare the products and update the best entry
        logic finish;  // load the result word and pulse the strobe
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;    // sweep counter sits on the last entry
        logic scan_empty;  // no entries in use
        logic scan_done;   // every entry in use has been read
    } t_status;

endpackage

// ----- rtl/weighted_least_connection_picker.sv -----
// Top level of the weighted least-connection picker.
//
//  Channel   Direction  Handshake                  Word
//  item      in         start high, busy low       wlc_pkg::t_item on i_item
//  result    out        o_strobe, one cycle        wlc_pkg::t_result on o_result
//  config    in         i_cfg_valid, o_cfg_ready   dest_count on i_cfg_data
//
// A write word never raises busy. A schedule word over n entries in use keeps busy
// high while the shared pair of cross-product multipliers and the comparison that
// follows them work through each entry in turn; the result appears as busy falls.
// With no entries in use busy stays low and the result is registered from the word.
// After reset busy stays high while the table is swept to zero.
// The receiver cannot stall; configuration is always ready.
module weighted_least_connection_picker #(
    parameter int MAX_DESTS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  wlc_pkg::t_item   i_item,
    output wlc_pkg::t_result o_result,
    output logic             o_strobe,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [6:0]       i_cfg_data
);

    wlc_pkg::t_cmd    cmd;
    wlc_pkg::t_status status;
    logic             cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Sequencer.
    wlc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_func   (i_item.func),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // Table, scan and comparison.
    wlc_datapath #(
        .MAX_DESTS (MAX_DESTS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cmd      (cmd),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_status   (status),
        .o_result   (o_result),
        .o_strobe   (o_strobe)
    );

    // A write word never produces a result.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.func == wlc_pkg::FUNC_WRITE) |=> !o_strobe)
        else $error("result strobe after a write word");

    // A result only follows a scan or an accepted schedule word.
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy || start))
        else $error("result strobe without a pending schedule word");

    // An empty result carries zero index and overhead.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.found) |->
            (o_result.chosen_index == 6'd0 && o_result.chosen_overhead == 32'd0))
        else $error("result without a destination carries nonzero fields");

endmodule

// ----- rtl/wlc_ctrl.sv -----
// Controller state machine of the weighted least-connection picker.
module wlc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_func,
    input  wlc_pkg::t_status i_status,
    output wlc_pkg::t_cmd   o_cmd,
    output logic            o_busy
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_MUL   = 2'd2;
    localparam logic [1:0] S_CMP   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // State register; reset enters the table clearing sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_func == wlc_pkg::FUNC_WRITE) begin
                        o_cmd.wr = 1'b1;
                    end else begin
                        o_cmd.init = 1'b1;
                        if (i_status.scan_empty) begin
                            o_cmd.finish = 1'b1;
                        end else begin
                            n_state = S_MUL;
                        end
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_status.scan_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_MUL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- rtl/wlc_datapath.sv -----
// Datapath of the weighted least-connection picker: table memory, scan counter and comparator.
module wlc_datapath #(
    parameter int MAX_DESTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wlc_pkg::t_item    i_item,
    input  wlc_pkg::t_cmd     i_cmd,
    input  logic              i_cfg_we,
    input  logic [6:0]        i_cfg_data,
    output wlc_pkg::t_status  o_status,
    output wlc_pkg::t_result  o_result,
    output logic              o_strobe
);

    localparam int IW = (MAX_DESTS > 1) ? $clog2(MAX_DESTS) : 1;
    localparam int CW = $clog2(MAX_DESTS + 1);
    localparam int MW = 49;

    // Table memory: {overloaded, weight, overhead}.
    logic [MW-1:0] mem [MAX_DESTS];

    logic [6:0]    r_dest_count;
    logic [CW-1:0] r_cnt;
    logic [MW-1:0] r_rd;

    logic [IW-1:0] r_cand_idx;
    logic          r_cand_ovl;
    logic [15:0]   r_cand_w;
    logic [31:0]   r_cand_oh;
    logic [47:0]   r_p_best;
    logic [47:0]   r_p_cand;

    logic          r_have;
    logic [IW-1:0] r_best_idx;
    logic [15:0]   r_best_w;
    logic [31:0]   r_best_oh;

    logic          r_strobe;
    wlc_pkg::t_result r_result;

    logic [CW-1:0]   n_scan;
    logic [CW+6:0]   count_ext;
    logic [CW-1:0]   cnt_inc;
    logic [IW+5:0]   widx_ext;
    logic            wr_in_range;
    logic            we;
    logic [IW-1:0]   waddr;
    logic [MW-1:0]   wdata;
    logic            re;
    logic [IW-1:0]   raddr;
    logic            take;
    logic            n_have;
    logic [IW-1:0]   n_best_idx;
    logic [31:0]     n_best_oh;
    logic [IW+5:0]   bidx_ext;

    // Configuration register: entries in use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_count <= '0;
        end else if (i_cfg_we) begin
            r_dest_count <= i_cfg_data;
        end
    end

    // Entries scanned, limited to the table size.
    assign count_ext = {{CW{1'b0}}, r_dest_count};
    assign n_scan    = ({25'd0, r_dest_count} > 32'(MAX_DESTS)) ? CW'(MAX_DESTS)
                                                                  : count_ext[CW-1:0];
    assign cnt_inc   = r_cnt + CW'(1);

    // Status towards the controller.
    assign o_status.clr_last   = (r_cnt == CW'(MAX_DESTS - 1));
    assign o_status.scan_empty = (n_scan == '0);
    assign o_status.scan_done  = (r_cnt == n_scan);

    // Sweep and scan counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.init) begin
            r_cnt <= '0;
        end else if (i_cmd.clr || i_cmd.mul) begin
            r_cnt <= cnt_inc;
        end
    end

    // Write port: the clearing sweep or a write word inside the table.
    assign widx_ext    = {{IW{1'b0}}, i_item.entry_index};
    assign wr_in_range = ({26'd0, i_item.entry_index} < 32'(MAX_DESTS));
    assign we          = i_cmd.clr || (i_cmd.wr && wr_in_range);
    assign waddr       = i_cmd.clr ? r_cnt[IW-1:0] : widx_ext[IW-1:0];
    assign wdata       = i_cmd.clr ? '0 : {i_item.entry_overloaded, i_item.entry_weight,
                                           i_item.entry_overhead};

    // Read port: entry zero at the start of a scan, then one ahead of the candidate.
    assign re    = i_cmd.init || (i_cmd.mul && (cnt_inc < CW'(MAX_DESTS)));
    assign raddr = i_cmd.init ? '0 : cnt_inc[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd <= mem[raddr];
        end
    end

    // Cross products of the candidate against the best entry so far.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_cand_idx <= r_cnt[IW-1:0];
            r_cand_ovl <= r_rd[48];
            r_cand_w   <= r_rd[47:32];
            r_cand_oh  <= r_rd[31:0];
            r_p_best   <= {16'd0, r_best_oh} * {32'd0, r_rd[47:32]};
            r_p_cand   <= {16'd0, r_rd[31:0]} * {32'd0, r_best_w};
        end
    end

    // The first usable entry is taken outright; later ones only with a strictly smaller ratio.
    assign take = i_cmd.cmp && !r_cand_ovl &&
                  (r_have ? (r_p_best > r_p_cand) : (r_cand_w != 16'd0));
    assign n_have     = i_cmd.init ? 1'b0 : (r_have || take);
    assign n_best_idx = take ? r_cand_idx : r_best_idx;
    assign n_best_oh  = take ? r_cand_oh : r_best_oh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_cmd.init || i_cmd.cmp) begin
            r_have <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_idx <= r_cand_idx;
            r_best_w   <= r_cand_w;
            r_best_oh  <= r_cand_oh;
        end
    end

    // Result word, registered when the scan ends and marked by a one-cycle strobe.
    assign bidx_ext = {6'd0, n_best_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_result.found           <= n_have;
            r_result.chosen_index    <= n_have ? bidx_ext[5:0] : 6'd0;
            r_result.chosen_overhead <= n_have ? n_best_oh : 32'd0;
        end
    end

    assign o_result = r_result;
    assign o_strobe = r_strobe;

endmodule

// ----- verif/weighted_least_connection_picker_tb.sv -----
// Self-checking testbench for the weighted least-connection picker: directed table, then random words.
module weighted_least_connection_picker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SIZE  = 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 2 * TABLE_SIZE + 8;

    // Kinds of row in the directed table.
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_WORD,
        ROW_PICK_KNOWN
    } t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [6:0]       count;
        wlc_pkg::t_item   word;
        wlc_pkg::t_result known;
    } t_dir_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    wlc_pkg::t_item   i_item;
    wlc_pkg::t_result o_result;
    logic             o_strobe;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [6:0]       i_cfg_data;

    // Shadow copy of the destination table and the active count.
    logic [15:0] weight_shadow     [TABLE_SIZE];
    logic [31:0] overhead_shadow   [TABLE_SIZE];
    logic        overloaded_shadow [TABLE_SIZE];
    logic [6:0]  dest_count_shadow;

    wlc_pkg::t_result pending_picks [$];
    t_dir_row         dir_rows [$];

    int n_errors;
    int n_writes;
    int n_picks;
    int n_found;
    int n_settings;
    int cycle_count;

    weighted_least_connection_picker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_result    (o_result),
        .o_strobe    (o_strobe),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 4 ns clock.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Run-away guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL weighted_least_connection_picker");
            $finish;
        end
    end

    // Least overhead per weight among the entries in use; ties keep the earlier entry.
    function automatic wlc_pkg::t_result pick_least_loaded();
        wlc_pkg::t_result res;
        logic        have;
        int unsigned span;
        int unsigned best;
        logic [47:0] lhs;
        logic [47:0] rhs;
        res  = '0;
        have = 1'b0;
        best = 0;
        span = (dest_count_shadow > TABLE_SIZE) ? TABLE_SIZE : dest_count_shadow;
        for (int unsigned i = 0; i < span; i++) begin
            if (overloaded_shadow[i]) continue;
            if (!have) begin
                if (weight_shadow[i] != 16'd0) begin
                    have = 1'b1;
                    best = i;
                end
                continue;
            end
            lhs = {16'd0, overhead_shadow[best]} * {32'd0, weight_shadow[i]};
            rhs = {16'd0, overhead_shadow[i]} * {32'd0, weight_shadow[best]};
            if (lhs > rhs) best = i;
        end
        if (have) begin
            res.found           = 1'b1;
            res.chosen_index    = best[5:0];
            res.chosen_overhead = overhead_shadow[best];
        end
        return res;
    endfunction

    // Directed table rows.
    function automatic t_dir_row row_cfg(input logic [6:0] count);
        t_dir_row r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.count = count;
        return r;
    endfunction

    function automatic t_dir_row row_write(input logic [5:0] idx, input logic [15:0] weight,
                                           input logic ovl, input logic [31:0] overhead);
        t_dir_row r;
        r                       = '0;
        r.kind                  = ROW_WORD;
        r.word.func             = wlc_pkg::FUNC_WRITE;
        r.word.entry_index      = idx;
        r.word.entry_weight     = weight;
        r.word.entry_overloaded = ovl;
        r.word.entry_overhead   = overhead;
        return r;
    endfunction

    // A pick word carries junk in its unused fields; the block must ignore it.
    function automatic t_dir_row row_pick();
        t_dir_row r;
        r           = '0;
        r.kind      = ROW_WORD;
        r.word      = '1;
        r.word.func = wlc_pkg::FUNC_SCHED;
        return r;
    endfunction

    function automatic t_dir_row row_pick_known(input logic found, input logic [5:0] idx,
                                                input logic [31:0] overhead);
        t_dir_row r;
        r                       = row_pick();
        r.kind                  = ROW_PICK_KNOWN;
        r.known.found           = found;
        r.known.chosen_index    = idx;
        r.known.chosen_overhead = overhead;
        return r;
    endfunction

    // Random word; most writes land inside the active span so that they matter.
    function automatic wlc_pkg::t_item random_word(input logic [6:0] count);
        wlc_pkg::t_item w;
        logic [63:0]    rnd;
        int unsigned    span;
        int unsigned    roll;
        span = (count > TABLE_SIZE) ? TABLE_SIZE : count;
        rnd  = {$urandom, $urandom};
        w    = rnd[$bits(wlc_pkg::t_item)-1:0];
        if ($urandom_range(0, 99) < 35) begin
            w.func = wlc_pkg::FUNC_SCHED;
            return w;
        end
        w.func = wlc_pkg::FUNC_WRITE;
        if (span > 0 && $urandom_range(0, 3) != 0)
            w.entry_index = 6'($urandom_range(0, span - 1));
        roll = $urandom_range(0, 99);
        if (roll < 15)      w.entry_weight = 16'd0;
        else if (roll < 50) w.entry_weight = 16'($urandom_range(1, 8));
        else if (roll < 85) w.entry_weight = 16'($urandom);
        else                w.entry_weight = 16'hFFFF;
        roll = $urandom_range(0, 99);
        if (roll < 10)      w.entry_overhead = 32'd0;
        else if (roll < 50) w.entry_overhead = 32'($urandom_range(0, 40));
        else if (roll < 90) w.entry_overhead = $urandom;
        else                w.entry_overhead = 32'hFFFF_FFFF;
        w.entry_overloaded = ($urandom_range(0, 4) == 0);
        return w;
    endfunction

    // Offer one word, wait for it to be taken, then update the shadow table or queue a pick.
    task automatic apply_word(input wlc_pkg::t_item w, input logic use_known,
                              input wlc_pkg::t_result known);
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
        if (w.func == wlc_pkg::FUNC_WRITE) begin
            weight_shadow[w.entry_index]     = w.entry_weight;
            overloaded_shadow[w.entry_index] = w.entry_overloaded;
            overhead_shadow[w.entry_index]   = w.entry_overhead;
            n_writes++;
        end else begin
            pending_picks.push_back(use_known ? known : pick_least_loaded());
            n_picks++;
        end
    endtask

    // Stop sending, let every outstanding pick come back, then wait until busy is low.
    task automatic drain();
        start <= 1'b0;
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic set_dest_count(input logic [6:0] count);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= count;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid       <= 1'b0;
        dest_count_shadow  = count;
        n_settings++;
    endtask

    // One random phase under a single dest_count setting.
    task automatic run_phase(input logic [6:0] count, input int words, input logic allow_idle,
                             input logic pause_midway);
        wlc_pkg::t_item w;
        logic           calm;
        calm = 1'b0;
        drain();
        set_dest_count(count);
        for (int k = 0; k < words; k++) begin
            if (k % 32 == 0) calm = ($urandom_range(0, 2) == 0);
            w = random_word(count);
            apply_word(w, 1'b0, '0);
            if (pause_midway && k == words / 2) begin
                start <= 1'b0;
                while (pending_picks.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end else if (allow_idle && !calm && $urandom_range(0, 3) == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
        end
    endtask

    // Compare each result word with the oldest pending pick.
    always @(posedge i_clk) begin : check_results
        wlc_pkg::t_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_picks.size() == 0) begin
                $error("result word with no pick pending: %h", o_result);
                n_errors++;
            end else begin
                want = pending_picks.pop_front();
                if (want.found) n_found++;
                if (o_result.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_result.found);
                    n_errors++;
                end
                if (o_result.chosen_index !== want.chosen_index) begin
                    $error("chosen_index: expected %0d, got %0d",
                           want.chosen_index, o_result.chosen_index);
                    n_errors++;
                end
                if (o_result.chosen_overhead !== want.chosen_overhead) begin
                    $error("chosen_overhead: expected %0h, got %0h",
                           want.chosen_overhead, o_result.chosen_overhead);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_item            = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_data        = '0;
        n_errors          = 0;
        n_writes          = 0;
        n_picks           = 0;
        n_found           = 0;
        n_settings        = 0;
        cycle_count       = 0;
        dest_count_shadow = '0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            weight_shadow[i]     = '0;
            overhead_shadow[i]   = '0;
            overloaded_shadow[i] = 1'b0;
        end

        dir_rows = '{
            // Nothing in use straight after reset.
            row_pick_known(1'b0, 6'd0, 32'd0),
            row_cfg(7'd64),
            // Whole table in use but every weight is still zero.
            row_pick_known(1'b0, 6'd0, 32'd0),
            row_write(6'd0, 16'hFFFF, 1'b0, 32'hFFFF_FFFF),
            row_pick_known(1'b1, 6'd0, 32'hFFFF_FFFF),
            row_write(6'd63, 16'd1, 1'b0, 32'd0),
            row_pick_known(1'b1, 6'd63, 32'd0),
            // An overloaded entry is never chosen.
            row_write(6'd63, 16'd1, 1'b1, 32'd0),
            row_pick_known(1'b1, 6'd0, 32'hFFFF_FFFF),
            // A later zero-weight entry cannot win.
            row_write(6'd5, 16'd0, 1'b0, 32'd0),
            row_pick_known(1'b1, 6'd0, 32'hFFFF_FFFF),
            // First entry quiesced: nothing left that is eligible.
            row_write(6'd0, 16'd0, 1'b0, 32'd7),
            row_pick_known(1'b0, 6'd0, 32'd0),
            // Equal ratios keep the earlier entry.
            row_write(6'd10, 16'd2, 1'b0, 32'd10),
            row_write(6'd20, 16'd4, 1'b0, 32'd20),
            row_pick_known(1'b1, 6'd10, 32'd10),
            row_write(6'd30, 16'hFFFF, 1'b0, 32'hFFFF_FFFE),
            row_write(6'd40, 16'd3, 1'b0, 32'd14),
            row_pick(),
            // Widest products.
            row_write(6'd63, 16'hFFFF, 1'b0, 32'hFFFF_FFFF),
            row_pick(),
            // A count above the table size scans the whole table.
            row_cfg(7'd127),
            row_pick(),
            row_cfg(7'd1),
            row_pick_known(1'b0, 6'd0, 32'd0),
            row_write(6'd0, 16'd1, 1'b1, 32'd1),
            row_pick_known(1'b0, 6'd0, 32'd0)
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The table is swept clear after reset.
        @(posedge i_clk);
        while (busy) @(posedge i_clk);

        foreach (dir_rows[r]) begin
            case (dir_rows[r].kind)
                ROW_CFG: begin
                    drain();
                    set_dest_count(dir_rows[r].count);
                end
                ROW_PICK_KNOWN: begin
                    apply_word(dir_rows[r].word, 1'b1, dir_rows[r].known);
                end
                default: begin
                    apply_word(dir_rows[r].word, 1'b0, '0);
                end
            endcase
        end

        run_phase(7'd127, 110, 1'b1, 1'b0);
        run_phase(7'd1, 90, 1'b1, 1'b0);
        run_phase(7'($urandom_range(2, 63)), 110, 1'b1, 1'b0);
        run_phase(7'd64, 110, 1'b1, 1'b1);
        run_phase(7'd0, 40, 1'b1, 1'b0);
        run_phase(7'($urandom_range(0, 127)), 140, 1'b1, 1'b0);
        run_phase(7'd64, 150, 1'b0, 1'b0);

        // Let the last picks return and watch for stray result words.
        start <= 1'b0;
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d table writes and %0d picks, %0d of which found a destination,",
                 n_writes, n_picks, n_found);
        $display("across %0d dest_count settings from empty to above the table size.",
                 n_settings);
        if (n_errors == 0) begin
            $display("PASS weighted_least_connection_picker");
        end else begin
            $display("FAIL weighted_least_connection_picker");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/wlc_pkg.sv
rtl/wlc_ctrl.sv
rtl/wlc_datapath.sv
rtl/weighted_least_connection_picker.sv
verif/weighted_least_connection_picker_tb.sv
